@@ hdl/mma_pkg.sv @@
// Shared widths, register indexes, mode codes and the divider request type
// for the multimode moving average block. No dependencies.
package mma_pkg;

	// Depth of the sample window ring; a power of two.
	localparam int MAX_WINDOW  = 256;
	// Width of one input sample, signed fixed point.
	localparam int SAMPLE_BITS = 32;
	// Width of one average, signed Q16.16.
	localparam int AVG_W       = 32;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

	localparam logic [MODE_W-1:0] MODE_SIMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WMA    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_WILDER = 2'd3;

	// Derived widths.
	localparam int RING_AW = $clog2(MAX_WINDOW);
	localparam int P_W     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W   = SAMPLE_BITS + RING_AW;
	localparam int WSUM_W  = SAMPLE_BITS + 2 * RING_AW;
	localparam int S_W     = SAMPLE_BITS + 2;
	localparam int MUL_W   = P_W + 1 + S_W;
	localparam int DIV_W   = WSUM_W;
	localparam int DVS_W   = 2 * P_W;
	localparam int CNT_W   = $clog2(DIV_W);

	// One request to the serial divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} mma_div_req_t;

endpackage

@@ hdl/mma_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/mma_div.sv @@
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
// Depends on mma_pkg for widths and the request type.
module mma_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mma_pkg::mma_div_req_t            req,
	output logic                             done,
	output logic signed [mma_pkg::DIV_W-1:0] quotient
);
	import mma_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] d_q;
	logic             neg_q;

	logic             dvd_neg;
	logic [DIV_W-1:0] dvd_mag;
	logic [DVS_W:0]   trial;
	logic             fits;

	// Magnitude of the dividend; the divisor is always positive.
	assign dvd_neg = req.dividend[DIV_W-1];
	assign dvd_mag = dvd_neg ? (~req.dividend + DIV_W'(1)) : req.dividend;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign trial = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign fits  = (trial >= {1'b0, d_q});

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dvd_mag;
			rem_q <= '0;
			d_q   <= req.divisor;
			neg_q <= dvd_neg;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, d_q}) : trial;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = signed'(neg_q ? (~quo_q + DIV_W'(1)) : quo_q);

endmodule

@@ hdl/multimode_moving_average.sv @@
// Multimode moving average: simple, exponential, linearly weighted and Wilder.
// Top level with the item sequencer; depends on mma_pkg, mma_ram and mma_div.
//
// Usage: samples enter on in_valid/in_stall with start_series and sample;
// averages leave on out_valid/out_stall as average. An item is taken at a
// clock edge with valid high and stall low.
// The configuration port writes avg_mode (index 0) or window_length (index 1)
// at an edge with cfg_we high while idle; writes at other times are ignored.
// Every write also starts a new series. Write it only while the block is idle;
// an item offered during a write is held off. Each series yields no average
// for its first p-1 samples (p is window_length clipped to 1..256) and one
// average for every sample after that.
// An item with no average passes S_READ and S_UPD; one with an average also
// passes S_PREP, S_LAUNCH, S_DIV, where the 48-bit serial divider produces one
// quotient bit per cycle, and S_OUT. in_stall stays high outside S_IDLE.
// The result sits in an output register, so the next item is accepted while
// it waits. If the receiver holds out_stall, the following result waits in
// the sequencer until the output register is free.
// Reset clears mode to simple, window_length to 1 and all series state.
module multimode_moving_average (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mma_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   start_series,
	input  logic signed [mma_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mma_pkg::AVG_W-1:0]       average
);
	import mma_pkg::*;

	localparam int CMP_W = (P_W > CFG_W) ? P_W : CFG_W;

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_UPD    = 3'd2;
	localparam logic [2:0] S_PREP   = 3'd3;
	localparam logic [2:0] S_LAUNCH = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0]                   state_q;
	logic [MODE_W-1:0]            mode_q;
	logic [CFG_W-1:0]             wlen_q;
	logic [P_W-1:0]               seen_q;
	logic [RING_AW-1:0]           slot_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic signed [WSUM_W-1:0]     wsum_q;
	logic signed [S_W-1:0]        s_q;
	logic                         first_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [DIV_W-1:0]             dvd_q;
	logic [DVS_W-1:0]             dvs_q;
	logic [AVG_W-1:0]             res_q;
	logic                         out_valid_q;
	logic [AVG_W-1:0]             average_q;

	logic [CMP_W-1:0]             wl_ext;
	logic [P_W-1:0]               p;
	logic                         steady;
	logic [RING_AW-1:0]           old_slot;
	logic [SAMPLE_BITS-1:0]       rd_data;
	logic [P_W-1:0]               mul_a;
	logic signed [S_W-1:0]        mul_b;
	logic signed [MUL_W-1:0]      prod;
	logic signed [SUM_W-1:0]      sum_nxt;
	logic signed [WSUM_W-1:0]     wsum_nxt;
	logic [DVS_W-1:0]             tri_div;
	logic signed [S_W:0]          diff2;
	logic [DIV_W-1:0]             dvd_sel;
	logic [DVS_W-1:0]             dvs_sel;
	mma_div_req_t                 div_req;
	logic                         div_done;
	logic signed [DIV_W-1:0]      div_quo;
	logic signed [DIV_W-1:0]      nv;
	logic [AVG_W-1:0]             nv_sat;
	logic                         in_take;
	logic                         out_load;

	// Effective period: zero acts as one, long windows clip to the ring depth.
	assign wl_ext = CMP_W'(wlen_q);
	always_comb begin
		if (wl_ext == '0) begin
			p = P_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			p = P_W'(MAX_WINDOW);
		end else begin
			p = P_W'(wl_ext);
		end
	end

	assign steady   = (seen_q >= p);
	assign old_slot = slot_q - RING_AW'(p);
	assign in_take  = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Window ring.
	mma_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == S_UPD),
		.waddr(slot_q),
		.wdata(x_q),
		.re   (state_q == S_READ),
		.raddr(old_slot),
		.rdata(rd_data)
	);

	// Shared multiplier: sample weight during update, (p-1)*s for Wilder.
	always_comb begin
		if (state_q == S_PREP) begin
			mul_a = p - P_W'(1);
			mul_b = s_q;
		end else begin
			mul_a = steady ? p : (seen_q + P_W'(1));
			mul_b = S_W'(x_q);
		end
	end
	assign prod = signed'({1'b0, mul_a}) * mul_b;

	// Running and weighted sums for the new sample.
	always_comb begin
		if (steady) begin
			sum_nxt  = sum_q - SUM_W'(signed'(rd_data)) + SUM_W'(x_q);
			wsum_nxt = wsum_q - WSUM_W'(sum_q) + WSUM_W'(prod);
		end else begin
			sum_nxt  = sum_q + SUM_W'(x_q);
			wsum_nxt = wsum_q + WSUM_W'(prod);
		end
	end

	// Dividend and divisor for the one division each average needs.
	assign tri_div = DVS_W'((DVS_W'(p) * (DVS_W'(p) + DVS_W'(1))) >> 1);
	assign diff2   = ((S_W + 1)'(x_q) - (S_W + 1)'(s_q)) <<< 1;
	always_comb begin
		case (mode_q)
			MODE_SIMPLE: begin
				dvd_sel = DIV_W'(sum_q);
				dvs_sel = DVS_W'(p);
			end
			MODE_EXP: begin
				dvd_sel = first_q ? DIV_W'(sum_q) : DIV_W'(diff2);
				dvs_sel = first_q ? DVS_W'(p) : (DVS_W'(p) + DVS_W'(1));
			end
			MODE_WMA: begin
				dvd_sel = DIV_W'(wsum_q);
				dvs_sel = tri_div;
			end
			default: begin
				dvd_sel = first_q ? DIV_W'(sum_q) : (DIV_W'(prod) + DIV_W'(x_q));
				dvs_sel = DVS_W'(p);
			end
		endcase
	end

	assign div_req.start    = (state_q == S_LAUNCH);
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dvs_q;

	mma_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	// New value from the quotient, then saturation to the output range.
	always_comb begin
		if (mode_q == MODE_EXP && !first_q) begin
			nv = DIV_W'(s_q) + div_quo;
		end else begin
			nv = div_quo;
		end
		if (nv[DIV_W-1:AVG_W-1] == '0 || nv[DIV_W-1:AVG_W-1] == '1) begin
			nv_sat = nv[AVG_W-1:0];
		end else if (nv[DIV_W-1]) begin
			nv_sat = {1'b1, {(AVG_W - 1){1'b0}}};
		end else begin
			nv_sat = {1'b0, {(AVG_W - 1){1'b1}}};
		end
	end

	// Sequencer, configuration and series state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_SIMPLE;
			wlen_q  <= CFG_W'(1);
			seen_q  <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
			wsum_q  <= '0;
			s_q     <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == REG_AVG_MODE) begin
							mode_q <= cfg_data[MODE_W-1:0];
						end else begin
							wlen_q <= cfg_data;
						end
						seen_q <= '0;
						slot_q <= '0;
						sum_q  <= '0;
						wsum_q <= '0;
						s_q    <= '0;
					end else if (in_take) begin
						if (start_series) begin
							seen_q <= '0;
							slot_q <= '0;
							sum_q  <= '0;
							wsum_q <= '0;
							s_q    <= '0;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					sum_q   <= sum_nxt;
					wsum_q  <= wsum_nxt;
					slot_q  <= slot_q + RING_AW'(1);
					first_q <= !steady;
					if (!steady) begin
						seen_q <= seen_q + P_W'(1);
					end
					if (steady || (seen_q + P_W'(1) == p)) begin
						state_q <= S_PREP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PREP: begin
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (mode_q == MODE_EXP || mode_q == MODE_WILDER) begin
							s_q <= S_W'(nv);
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and division operands.
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= sample;
		end
		if (state_q == S_PREP) begin
			dvd_q <= dvd_sel;
			dvs_q <= dvs_sel;
		end
		if (state_q == S_DIV && div_done) begin
			res_q <= nv_sat;
		end
		if (out_load) begin
			average_q <= res_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// A configuration write holds off the input for that cycle.
	assign in_stall  = (state_q != S_IDLE) || cfg_we;
	assign out_valid = out_valid_q;
	assign average   = signed'(average_q);

	// A new average only appears right after the output stage of the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("average presented without a finished division");

	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	// The sample count never runs past the effective period.
	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= p)
		else $error("sample count exceeds the period");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for multimode_moving_average: directed table, then random phases.
// Depends on mma_pkg and the multimode_moving_average RTL only.
`timescale 1ns / 100ps

module tb;
	import mma_pkg::*;

	localparam int SETTLE_CYCLES = 10;
	localparam int TAIL_CYCLES   = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 3000;
	localparam int RANDOM_ITEMS  = 1525;
	localparam int DIR_ROWS      = 32;
	// Phase in which the receiver holds off, and phase in which the sender waits mid-series.
	localparam int HOLD_PHASE    = 2;
	localparam int PAUSE_PHASE   = 4;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_W-1:0]       reg_value;
		logic                   restart;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   typed;
		logic [AVG_W-1:0]       typed_avg;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_series = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [AVG_W-1:0] average;

	// Predictor state: configuration and series.
	logic [MODE_W-1:0] cur_mode = MODE_SIMPLE;
	logic [CFG_W-1:0] cur_len = 9'd1;
	longint ring_copy [MAX_WINDOW];
	int unsigned slot_next = 0;
	int unsigned seen_count = 0;
	longint plain_sum = 0;
	longint weight_sum = 0;
	longint smooth_val = 0;

	logic signed [AVG_W-1:0] pending_averages[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_watch = 0;
	bit offering = 1'b0;
	bit hold_off_req = 1'b0;

	// Directed table: extremes, every mode, period zero and too long, restart mid-series.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b1, 32'h80000000, 1'b1, 32'h80000000},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00000000, 1'b1, 32'h00000000},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{ROW_WRITE, REG_WINDOW_LENGTH, 9'd0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00010000, 1'b1, 32'h00010000},
		'{ROW_WRITE, REG_AVG_MODE, {7'd0, MODE_WMA}, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_WRITE, REG_WINDOW_LENGTH, 9'd2, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h80000000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h80000000, 1'b0, 32'h0},
		'{ROW_WRITE, REG_AVG_MODE, {7'd0, MODE_EXP}, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_WRITE, REG_WINDOW_LENGTH, 9'd3, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00030000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'hFFFD0000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00060000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b1, 32'h12340000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'hFEDC8000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00000001, 1'b0, 32'h0},
		'{ROW_WRITE, REG_AVG_MODE, {7'd0, MODE_WILDER}, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h80000000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h80000000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00008000, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'hFFFFFFFF, 1'b0, 32'h0},
		'{ROW_WRITE, REG_WINDOW_LENGTH, 9'h1FF, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h80000001, 1'b0, 32'h0},
		'{ROW_WRITE, REG_AVG_MODE, {7'd0, MODE_SIMPLE}, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_SAMPLE, REG_AVG_MODE, 9'd0, 1'b0, 32'h00000001, 1'b0, 32'h0}
	};

	multimode_moving_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_series(start_series),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average(average)
	);

	always #5 clk = ~clk;

	// Clear the series state of the predictor.
	function automatic void clear_series();
		slot_next = 0;
		seen_count = 0;
		plain_sum = 0;
		weight_sum = 0;
		smooth_val = 0;
	endfunction

	// Advance the predictor by one item; returns 1 when the item yields an average.
	function automatic bit advance_average(input logic restart,
			input logic signed [SAMPLE_BITS-1:0] smp, output logic signed [AVG_W-1:0] avg);
		longint p;
		longint x;
		longint oldest;
		longint a;
		bit first;
		p = (cur_len == 0) ? 1 : ((cur_len > MAX_WINDOW) ? MAX_WINDOW : cur_len);
		x = smp;
		avg = '0;
		if (restart)
			clear_series();
		if (seen_count >= p) begin
			oldest = ring_copy[(slot_next + MAX_WINDOW - p) % MAX_WINDOW];
			weight_sum = weight_sum - plain_sum + p * x;
			plain_sum = plain_sum - oldest + x;
		end else begin
			weight_sum += longint'(seen_count + 1) * x;
			plain_sum += x;
		end
		ring_copy[slot_next] = x;
		slot_next = (slot_next + 1) % MAX_WINDOW;
		first = 1'b0;
		if (seen_count < p) begin
			seen_count++;
			if (seen_count < p)
				return 1'b0;
			first = 1'b1;
		end
		// The smoothed modes are seeded with the first window mean.
		if (first)
			smooth_val = plain_sum / p;
		else if (cur_mode == MODE_EXP)
			smooth_val += (2 * (x - smooth_val)) / (p + 1);
		else if (cur_mode == MODE_WILDER)
			smooth_val = ((p - 1) * smooth_val + x) / p;
		if (cur_mode == MODE_SIMPLE)
			a = plain_sum / p;
		else if (cur_mode == MODE_WMA)
			a = weight_sum / ((p * (p + 1)) / 2);
		else
			a = smooth_val;
		if (a > 64'sd2147483647)
			a = 64'sd2147483647;
		if (a < -64'sd2147483648)
			a = -64'sd2147483648;
		avg = a[AVG_W-1:0];
		return 1'b1;
	endfunction

	// Stop offering items; valid is lowered at most once per time step.
	task automatic drop_offer();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			drop_offer();
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Wait until every expected average has come out.
	task automatic drain_results();
		drop_offer();
		while (pending_averages.size() != 0)
			@(posedge clk);
	endtask

	// Offer one item, wait for acceptance, then record what it should yield.
	task automatic offer_item(input logic restart, input logic [SAMPLE_BITS-1:0] smp,
			input logic typed, input logic [AVG_W-1:0] typed_avg);
		logic signed [AVG_W-1:0] predicted;
		bit yields;
		in_valid <= 1'b1;
		start_series <= restart;
		sample <= smp;
		offering = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		yields = advance_average(restart, smp, predicted);
		if (yields)
			pending_averages.push_back(typed ? typed_avg : predicted);
	endtask

	// Write one register once the block is idle; every write restarts the series.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_AVG_MODE)
			cur_mode = value[MODE_W-1:0];
		else
			cur_len = value;
		clear_series();
		@(posedge clk);
	endtask

	// Compare each accepted average with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_averages.size() == 0) begin
				$error("average: unexpected result %0d", average);
				mismatch_count++;
			end else if (average !== pending_averages[0]) begin
				$error("average: expected %0d, got %0d", pending_averages[0], average);
				mismatch_count++;
				void'(pending_averages.pop_front());
			end else begin
				void'(pending_averages.pop_front());
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_watch = 0;
			else
				idle_watch++;
			if (idle_watch >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: stall patterns that change over time, plus one long hold-off on request.
	initial begin : receiver
		int unsigned pattern_left;
		int unsigned stall_pct;
		int unsigned held;
		pattern_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(32, 256);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				pattern_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Stimulus: reset, directed table, then random phases of settings and series.
	initial begin : stimulus
		int unsigned rand_sent;
		int unsigned phase_no;
		int unsigned n_items;
		int unsigned k;
		int unsigned burst_left;
		int unsigned gap_max;
		int unsigned pick;
		bit gap_free;
		logic [MODE_W-1:0] mode_pick;
		logic [CFG_W-1:0] len_pick;
		logic [SAMPLE_BITS-1:0] smp;
		logic restart;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE)
				write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
			else
				offer_item(dir_rows[i].restart, dir_rows[i].smp, dir_rows[i].typed,
						dir_rows[i].typed_avg);
		end

		rand_sent = 0;
		phase_no = 0;
		burst_left = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			// Pick the settings of this phase; short windows dominate.
			mode_pick = MODE_W'($urandom_range(0, 3));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len_pick = CFG_W'($urandom_range(1, 8));
			else if (pick < 87)
				len_pick = CFG_W'($urandom_range(9, 40));
			else if (pick < 92)
				len_pick = CFG_W'(MAX_WINDOW);
			else if (pick < 96)
				len_pick = CFG_W'($urandom_range(MAX_WINDOW + 1, 511));
			else
				len_pick = '0;
			if (phase_no == HOLD_PHASE)
				len_pick = CFG_W'(2);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_AVG_MODE, {7'($urandom_range(0, 127)), mode_pick});
				write_reg(REG_WINDOW_LENGTH, len_pick);
			end else begin
				write_reg(REG_WINDOW_LENGTH, len_pick);
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_AVG_MODE, {7'($urandom_range(0, 127)), mode_pick});
			end

			n_items = ((len_pick == 0) ? 1 : ((len_pick > MAX_WINDOW) ? MAX_WINDOW : len_pick))
					+ $urandom_range(4, 48);
			gap_free = ($urandom_range(0, 3) == 0) || (phase_no == HOLD_PHASE);
			gap_max = $urandom_range(1, 12);
			if (phase_no == HOLD_PHASE) begin
				n_items = 80;
				hold_off_req = 1'b1;
			end

			for (k = 0; k < n_items; k++) begin
				if (burst_left == 0) begin
					pause_sender(gap_free ? 0 : $urandom_range(1, gap_max));
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;
				case ($urandom_range(0, 9))
					0: smp = 32'h7FFFFFFF;
					1: smp = 32'h80000000;
					2, 3, 4: smp = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
					default: smp = $urandom;
				endcase
				restart = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
				offer_item(restart, smp, 1'b0, '0);
				rand_sent++;
				// Once, the sender waits in mid-series for every result to come out.
				if (phase_no == PAUSE_PHASE && k == n_items / 2)
					drain_results();
			end
			phase_no++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_averages.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
